[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/qte_pkg.sv]
// Types, codes and constants of the quaternion to Euler angle block.
package qte_pkg;
	localparam int QW    = 16;
	localparam int AW    = 16;
	localparam int VW    = 36;
	localparam int GW    = 34;
	localparam int THR_W = 14;
	localparam int RAD_W = 62;
	localparam int ROOT_W = RAD_W / 2;

	typedef logic signed [QW-1:0] comp_t;
	typedef logic signed [AW-1:0] angle_t;
	typedef logic [1:0]           case_t;
	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [GW-1:0] ang_t;

	localparam case_t CASE_REG   = 2'd0;
	localparam case_t CASE_NORTH = 2'd1;
	localparam case_t CASE_SOUTH = 2'd2;
	localparam case_t CASE_ZERO  = 2'd3;

	localparam logic [1:0]       ADDR_THR  = 2'd0;
	localparam logic [THR_W-1:0] THR_RESET = 14'd8176;

	localparam vec_t   VEC_ONE     = 36'sd1073741824;
	localparam ang_t   ANG_QUARTER = 34'sd1073741824;
	localparam angle_t PITCH_POLE  = 16'sd16384;
	localparam logic [RAD_W-1:0] RAD_ONE = {2'b01, {(RAD_W-2){1'b0}}};

	// atan(2^-i) in binary angle, 2^31 = pi
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};
endpackage

[rtl/qte_quat_if.sv]
// Quaternion input channel: valid/ready handshake with four components.
interface qte_quat_if;
	import qte_pkg::*;
	logic  valid;
	logic  ready;
	comp_t quat_w;
	comp_t quat_x;
	comp_t quat_y;
	comp_t quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[rtl/qte_euler_if.sv]
// Euler angle output channel: valid/ready handshake with angles and case code.
interface qte_euler_if;
	import qte_pkg::*;
	logic   valid;
	logic   ready;
	angle_t roll_angle;
	angle_t pitch_angle;
	angle_t yaw_angle;
	case_t  result_case;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, result_case,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, result_case,
		output ready);
endinterface

[rtl/quaternion_to_euler_angles_top.sv]
// Top level: quaternion to roll/pitch/yaw with pole detection, fully pipelined.
//
// Channels: quat (sink) takes w, x, y, z in signed Q1.14; euler (source)
// gives roll, pitch and yaw in binary angle units (32768 = pi) and a case code
// (regular, north pole, south pole, zero quaternion). A transfer happens on
// a rising edge with valid and ready both high. The APB port holds the pole
// threshold at address 0; a write takes effect in the access phase.
// Throughput: one quaternion per cycle while the output is not stalled.
// The pipeline holds the two 31-stage square roots, the COMP_WIDTH-1
// stage normalizing divider and the CORDIC stages.
// Reset clears all valid bits and loads the threshold with 8176.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and quat.ready drops; nothing is lost or repeated.
// While the output slot is empty the pipeline keeps moving and takes new
// quaternions.
`include "assert_macros.svh"

module quaternion_to_euler_angles_top #(
	parameter int COMP_WIDTH   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);
	import qte_pkg::*;

	localparam int CW  = COMP_WIDTH;
	localparam int F   = CW - 2;
	localparam int QB  = F + 1;
	localparam int DW  = F + 31;
	localparam int PW  = 2 * CW;
	localparam int SH  = 2 * F - 30;
	localparam int SHR = (SH >= 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam int SC  = 30 - F;
	localparam int L   = 7 + 2 * ROOT_W + QB + CORDIC_STEPS;
	localparam logic [QB-1:0] QONE = {1'b1, {F{1'b0}}};
	localparam vec_t BAM_HALF = 36'sd32768;

	typedef logic signed [CW-1:0] ncomp_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [PW:0]   psum_t;

	typedef struct packed {
		comp_t w;
		comp_t x;
		comp_t y;
		comp_t z;
		logic  zero;
	} sd1_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       zero;
	} sd2_t;

	typedef struct packed {
		case_t              cs;
		logic signed [31:0] s;
		vec_t               rx;
		vec_t               ry;
		vec_t               yx;
		vec_t               yy;
	} sd3_t;

	function automatic vec_t to_q30(input psum_t v);
		return vec_t'(v >>> SHR) <<< SHL;
	endfunction

	function automatic angle_t bam(input vec_t v);
		vec_t t;
		t = v + BAM_HALF;
		return angle_t'(t[31:16]);
	endfunction

	// configuration register
	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_THR)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_THR) ? 32'(thr_q) : '0;

	// pipeline control
	logic [L-1:0] vld_s;
	logic         en;

	assign en         = !vld_s[L-1] || euler.ready;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-2:0], quat.valid};
		end
	end

	// s1: capture and squares
	comp_t       w_s1, x_s1, y_s1, z_s1;
	logic [31:0] sq_s1 [4];
	logic        zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1     <= quat.quat_w;
			x_s1     <= quat.quat_x;
			y_s1     <= quat.quat_y;
			z_s1     <= quat.quat_z;
			sq_s1[0] <= quat.quat_w * quat.quat_w;
			sq_s1[1] <= quat.quat_x * quat.quat_x;
			sq_s1[2] <= quat.quat_y * quat.quat_y;
			sq_s1[3] <= quat.quat_z * quat.quat_z;
			zero_s1  <= (quat.quat_w == '0) && (quat.quat_x == '0) &&
				(quat.quat_y == '0) && (quat.quat_z == '0);
		end
	end

	// s2: squared norm
	logic [33:0] n2_s2;
	sd1_t        sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s2 <= 34'(sq_s1[0]) + 34'(sq_s1[1]) + 34'(sq_s1[2]) + 34'(sq_s1[3]);
			sd_s2 <= '{w: w_s1, x: x_s1, y: y_s1, z: z_s1, zero: zero_s1};
		end
	end

	// norm root r = floor(sqrt(n2 * 2^28))
	logic [ROOT_W-1:0] r1;
	sd1_t              sd1_s [ROOT_W];

	qte_isqrt #(.RW(RAD_W)) u_norm_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({n2_s2, 28'b0}),
		.root (r1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd1_s[0] <= sd_s2;
			for (int k = 1; k < ROOT_W; k++) begin
				sd1_s[k] <= sd1_s[k-1];
			end
		end
	end

	// normalizing divider, one quotient bit per stage, four lanes w x y z
	comp_t             c_d [4];
	logic [DW-1:0]     drem_s [4][QB-1];
	logic [QB-1:0]     dq_s   [4][QB];
	logic [ROOT_W-1:0] dr_s   [QB-1];
	sd2_t              sd2_s  [QB];

	assign c_d[0] = sd1_s[ROOT_W-1].w;
	assign c_d[1] = sd1_s[ROOT_W-1].x;
	assign c_d[2] = sd1_s[ROOT_W-1].y;
	assign c_d[3] = sd1_s[ROOT_W-1].z;

	always_ff @(posedge clk) begin
		if (en) begin
			sd2_s[0] <= '{neg: {c_d[3][QW-1], c_d[2][QW-1], c_d[1][QW-1], c_d[0][QW-1]},
				zero: sd1_s[ROOT_W-1].zero};
			dr_s[0]  <= r1;
			for (int k = 1; k < QB; k++) begin
				sd2_s[k] <= sd2_s[k-1];
			end
			for (int k = 1; k < QB - 1; k++) begin
				dr_s[k] <= dr_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [QW-1:0] mag;
		logic [DW-1:0] num0;

		assign mag  = c_d[l][QW-1] ? QW'(-c_d[l]) : QW'(c_d[l]);
		assign num0 = DW'({mag, {(F+14){1'b0}}}) + DW'(r1 >> 1);

		for (genvar j = 0; j < QB; j++) begin : g_bit
			logic [DW-1:0]     rem_i;
			logic [QB-1:0]     q_i;
			logic [ROOT_W-1:0] r_i;
			logic [DW-1:0]     dsh;
			logic              ge;

			if (j == 0) begin : g_first
				assign rem_i = num0;
				assign q_i   = '0;
				assign r_i   = r1;
			end else begin : g_next
				assign rem_i = drem_s[l][j-1];
				assign q_i   = dq_s[l][j-1];
				assign r_i   = dr_s[j-1];
			end

			assign dsh = DW'(r_i) << (QB - 1 - j);
			assign ge  = rem_i >= dsh;

			always_ff @(posedge clk) begin
				if (en) begin
					dq_s[l][j] <= q_i | (QB'(ge) << (QB - 1 - j));
				end
			end

			if (j < QB - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						drem_s[l][j] <= ge ? (rem_i - dsh) : rem_i;
					end
				end
			end
		end
	end

	// signed normalized components
	ncomp_t nc [4];

	for (genvar l = 0; l < 4; l++) begin : g_nc
		logic [QB-1:0] qs;
		ncomp_t        ext;

		assign qs    = (dq_s[l][QB-1] > QONE) ? QONE : dq_s[l][QB-1];
		assign ext   = ncomp_t'({1'b0, qs});
		assign nc[l] = sd2_s[QB-1].neg[l] ? -ext : ext;
	end

	// s3: products
	prod_t  pxy_s3, pzw_s3, pyw_s3, pxz_s3, pyy_s3, pzz_s3, pxw_s3, pyz_s3, pxx_s3;
	ncomp_t nx_s3, nw_s3;
	logic   zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pxy_s3  <= nc[1] * nc[2];
			pzw_s3  <= nc[3] * nc[0];
			pyw_s3  <= nc[2] * nc[0];
			pxz_s3  <= nc[1] * nc[3];
			pyy_s3  <= nc[2] * nc[2];
			pzz_s3  <= nc[3] * nc[3];
			pxw_s3  <= nc[1] * nc[0];
			pyz_s3  <= nc[2] * nc[3];
			pxx_s3  <= nc[1] * nc[1];
			nx_s3   <= nc[1];
			nw_s3   <= nc[0];
			zero_s3 <= sd2_s[QB-1].zero;
		end
	end

	// s4: sums in Q30
	vec_t test_s4, numr_s4, denr_s4, numy_s4, deny_s4, xsc_s4, wsc_s4;
	logic zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			test_s4 <= to_q30(psum_t'(pxy_s3) + psum_t'(pzw_s3));
			numr_s4 <= to_q30(psum_t'(pyw_s3) - psum_t'(pxz_s3)) <<< 1;
			denr_s4 <= VEC_ONE - (to_q30(psum_t'(pyy_s3) + psum_t'(pzz_s3)) <<< 1);
			numy_s4 <= to_q30(psum_t'(pxw_s3) - psum_t'(pyz_s3)) <<< 1;
			deny_s4 <= VEC_ONE - (to_q30(psum_t'(pxx_s3) + psum_t'(pzz_s3)) <<< 1);
			xsc_s4  <= vec_t'(nx_s3) <<< SC;
			wsc_s4  <= vec_t'(nw_s3) <<< SC;
			zero_s4 <= zero_s3;
		end
	end

	// s5: pole test, sine and its square
	vec_t               thr30, s2x, s_sat;
	logic signed [31:0] s_n;
	logic signed [63:0] ss_n;
	logic               north, south;
	case_t              cs_n;
	sd3_t               sd_s5;
	logic [RAD_W-1:0]   ss_s5;

	always_comb begin
		thr30 = vec_t'({thr_q, 16'b0});
		north = test_s4 > thr30;
		south = test_s4 < -thr30;
		s2x   = test_s4 <<< 1;
		if (s2x > VEC_ONE) begin
			s_sat = VEC_ONE;
		end else if (s2x < -VEC_ONE) begin
			s_sat = -VEC_ONE;
		end else begin
			s_sat = s2x;
		end
		s_n  = $signed(s_sat[31:0]);
		ss_n = s_n * s_n;
		if (zero_s4) begin
			cs_n = CASE_ZERO;
		end else if (north) begin
			cs_n = CASE_NORTH;
		end else if (south) begin
			cs_n = CASE_SOUTH;
		end else begin
			cs_n = CASE_REG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s5    <= ss_n[RAD_W-1:0];
			sd_s5.cs <= cs_n;
			sd_s5.s  <= s_n;
			sd_s5.rx <= (north || south) ? wsc_s4 : denr_s4;
			sd_s5.ry <= (north || south) ? xsc_s4 : numr_s4;
			sd_s5.yx <= deny_s4;
			sd_s5.yy <= numy_s4;
		end
	end

	// cosine for the asin: floor(sqrt(1 - s^2))
	logic [ROOT_W-1:0] c2;
	sd3_t              sd3_s [ROOT_W];

	qte_isqrt #(.RW(RAD_W)) u_cos_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (RAD_ONE - ss_s5),
		.root (c2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd3_s[0] <= sd_s5;
			for (int k = 1; k < ROOT_W; k++) begin
				sd3_s[k] <= sd3_s[k-1];
			end
		end
	end

	// three atan2 units
	ang_t  roll_a, pitch_a, yaw_a;
	case_t cs_s [CORDIC_STEPS+1];

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk (clk),
		.en  (en),
		.xin (sd3_s[ROOT_W-1].rx),
		.yin (sd3_s[ROOT_W-1].ry),
		.ang (roll_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk (clk),
		.en  (en),
		.xin (vec_t'(c2)),
		.yin (vec_t'(sd3_s[ROOT_W-1].s)),
		.ang (pitch_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk (clk),
		.en  (en),
		.xin (sd3_s[ROOT_W-1].yx),
		.yin (sd3_s[ROOT_W-1].yy),
		.ang (yaw_a)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s[0] <= sd3_s[ROOT_W-1].cs;
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				cs_s[k] <= cs_s[k-1];
			end
		end
	end

	// s6: output register
	vec_t   ra2;
	angle_t roll_n, pitch_n, yaw_n;
	angle_t roll_s6, pitch_s6, yaw_s6;
	case_t  case_s6;

	always_comb begin
		ra2 = vec_t'(roll_a) <<< 1;
		case (cs_s[CORDIC_STEPS])
			CASE_REG: begin
				roll_n  = bam(vec_t'(roll_a));
				pitch_n = bam(vec_t'(pitch_a));
				yaw_n   = bam(vec_t'(yaw_a));
			end
			CASE_NORTH: begin
				roll_n  = bam(ra2);
				pitch_n = PITCH_POLE;
				yaw_n   = '0;
			end
			CASE_SOUTH: begin
				roll_n  = bam(-ra2);
				pitch_n = -PITCH_POLE;
				yaw_n   = '0;
			end
			default: begin
				roll_n  = '0;
				pitch_n = '0;
				yaw_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s6  <= roll_n;
			pitch_s6 <= pitch_n;
			yaw_s6   <= yaw_n;
			case_s6  <= cs_s[CORDIC_STEPS];
		end
	end

	assign euler.valid       = vld_s[L-1];
	assign euler.roll_angle  = roll_s6;
	assign euler.pitch_angle = pitch_s6;
	assign euler.yaw_angle   = yaw_s6;
	assign euler.result_case = case_s6;

	`QTE_ASSERT_IMP(a_zero_out, euler.valid && (euler.result_case == CASE_ZERO),
		(euler.roll_angle == '0) && (euler.pitch_angle == '0) && (euler.yaw_angle == '0),
		"zero quaternion gave nonzero angles")
	`QTE_ASSERT_IMP(a_north_out, euler.valid && (euler.result_case == CASE_NORTH),
		(euler.pitch_angle == PITCH_POLE) && (euler.yaw_angle == '0),
		"north pole result malformed")
	`QTE_ASSERT_IMP(a_south_out, euler.valid && (euler.result_case == CASE_SOUTH),
		(euler.pitch_angle == -PITCH_POLE) && (euler.yaw_angle == '0),
		"south pole result malformed")
	`QTE_ASSERT_NXT(a_thr_write, psel && penable && pwrite && (paddr == ADDR_THR),
		thr_q == $past(pwdata[THR_W-1:0]), "threshold write lost")
endmodule

[rtl/qte_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qte_isqrt #(
	parameter int RW = 62
) (
	input  logic            clk,
	input  logic            en,
	input  logic [RW-1:0]   rad,
	output logic [RW/2-1:0] root
);
	localparam int N = RW / 2;

	logic [N:0]    rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [RW-1:0] rad_s  [N-1];

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [N:0]    rem_i;
		logic [N-1:0]  root_i;
		logic [RW-1:0] rad_i;
		logic [N+2:0]  cur;
		logic [N+2:0]  trial;
		logic [N+2:0]  diff;

		if (j == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign rad_i  = rad_s[j-1];
		end

		assign cur   = {rem_i, rad_i[RW-1:RW-2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[j]  <= diff[N:0];
					root_s[j] <= {root_i[N-2:0], 1'b1};
				end else begin
					rem_s[j]  <= cur[N:0];
					root_s[j] <= {root_i[N-2:0], 1'b0};
				end
			end
		end

		if (j < N - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[j] <= rad_i << 2;
				end
			end
		end
	end

	assign root = root_s[N-1];
endmodule

[rtl/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in 32-bit binary angle.
module qte_cordic #(
	parameter int STEPS = 16
) (
	input  logic          clk,
	input  logic          en,
	input  qte_pkg::vec_t xin,
	input  qte_pkg::vec_t yin,
	output qte_pkg::ang_t ang
);
	import qte_pkg::*;

	vec_t x_s [STEPS];
	vec_t y_s [STEPS];
	ang_t a_s [STEPS+1];
	logic z_s [STEPS+1];

	// quadrant pre-rotation into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= (xin == '0) && (yin == '0);
			if (xin < 0) begin
				if (yin >= 0) begin
					x_s[0] <= yin;
					y_s[0] <= -xin;
					a_s[0] <= ANG_QUARTER;
				end else begin
					x_s[0] <= -yin;
					y_s[0] <= xin;
					a_s[0] <= -ANG_QUARTER;
				end
			end else begin
				x_s[0] <= xin;
				y_s[0] <= yin;
				a_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		vec_t xs;
		vec_t ys;
		ang_t tab;

		assign xs  = x_s[i] >>> i;
		assign ys  = y_s[i] >>> i;
		assign tab = ang_t'({2'b00, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				if (y_s[i] > 0) begin
					a_s[i+1] <= a_s[i] + tab;
				end else begin
					a_s[i+1] <= a_s[i] - tab;
				end
			end
		end

		if (i < STEPS - 1) begin : g_vec
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[i] > 0) begin
						x_s[i+1] <= x_s[i] + ys;
						y_s[i+1] <= y_s[i] - xs;
					end else begin
						x_s[i+1] <= x_s[i] - ys;
						y_s[i+1] <= y_s[i] + xs;
					end
				end
			end
		end
	end

	assign ang = z_s[STEPS] ? '0 : a_s[STEPS];
endmodule

[sim/testbench.sv]
// Self-checking testbench for the quaternion to Euler angle block.
module testbench;
	import qte_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct {
		angle_t roll;
		angle_t pitch;
		angle_t yaw;
		case_t  rcase;
	} euler_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	qte_quat_if  quat_ch();
	qte_euler_if euler_ch();

	quaternion_to_euler_angles_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.quat(quat_ch), .euler(euler_ch)
	);

	euler_exp_t       angle_queue[$];
	logic [THR_W-1:0] thr_shadow = THR_RESET;
	bit               no_idle = 1'b0;
	int               errs = 0;
	int               sent = 0;
	int               checked = 0;
	int               pole_hits = 0;
	int               idle_cycles = 0;

	initial begin
		quat_ch.valid = 1'b0;
		quat_ch.quat_w = '0;
		quat_ch.quat_x = '0;
		quat_ch.quat_y = '0;
		quat_ch.quat_z = '0;
		euler_ch.ready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rt, b;
		rt = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= rt + b) begin
				v -= rt + b;
				rt = (rt >> 1) + b;
			end else begin
				rt >>= 1;
			end
			b >>= 2;
		end
		return rt;
	endfunction

	function automatic longint unit_comp(longint cv, longint unsigned rad);
		longint unsigned m, q;
		m = cv < 0 ? -cv : cv;
		q = ((m << 28) + (rad >> 1)) / rad;
		if (q > 16384)
			q = 16384;
		return cv < 0 ? -longint'(q) : longint'(q);
	endfunction

	// vectoring rotation, result in 32-bit binary angle
	function automatic longint vector_angle(longint yv, longint xv);
		longint acc, t, xs, ys;
		acc = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv; yv = -t; acc = 64'sd1 << 30;
			end else begin
				xv = -yv; yv = t; acc = -(64'sd1 << 30);
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = xv >>> i;
			ys = yv >>> i;
			if (yv > 0) begin
				xv += ys; yv -= xs; acc += longint'(ATAN_TAB[i]);
			end else begin
				xv -= ys; yv += xs; acc -= longint'(ATAN_TAB[i]);
			end
		end
		return acc;
	endfunction

	function automatic angle_t to_bam(longint a);
		return angle_t'((a + 32768) >>> 16);
	endfunction

	function automatic euler_exp_t euler_from_quat(comp_t qw, comp_t qx, comp_t qy,
			comp_t qz, logic [THR_W-1:0] thr);
		euler_exp_t e;
		longint w, x, y, z, tst, th, num, den, s, cs, a;
		longint unsigned n2, rad;
		w = qw; x = qx; y = qy; z = qz;
		if (w == 0 && x == 0 && y == 0 && z == 0) begin
			e = '{0, 0, 0, CASE_ZERO};
			return e;
		end
		n2 = w * w + x * x + y * y + z * z;
		rad = int_sqrt(n2 << 28);
		w = unit_comp(w, rad); x = unit_comp(x, rad);
		y = unit_comp(y, rad); z = unit_comp(z, rad);
		tst = (x * y + z * w) * 4;
		th = longint'(thr) << 16;
		if (tst > th || tst < -th) begin
			a = vector_angle(x * 65536, w * 65536);
			e.roll = to_bam(tst > th ? 2 * a : -2 * a);
			e.pitch = tst > th ? PITCH_POLE : -PITCH_POLE;
			e.yaw = '0;
			e.rcase = tst > th ? CASE_NORTH : CASE_SOUTH;
			return e;
		end
		num = 2 * ((y * w - x * z) * 4);
		den = (64'sd1 << 30) - 2 * ((y * y + z * z) * 4);
		e.roll = to_bam(vector_angle(num, den));
		s = 2 * tst;
		if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
		if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
		cs = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
		e.pitch = to_bam(vector_angle(s, cs));
		num = 2 * ((x * w - y * z) * 4);
		den = (64'sd1 << 30) - 2 * ((x * x + z * z) * 4);
		e.yaw = to_bam(vector_angle(num, den));
		e.rcase = CASE_REG;
		return e;
	endfunction

	task automatic send_quat(int qw, int qx, int qy, int qz);
		euler_exp_t e;
		if (!no_idle && $urandom_range(99) < 35) begin
			quat_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		quat_ch.valid <= 1'b1;
		quat_ch.quat_w <= comp_t'(qw);
		quat_ch.quat_x <= comp_t'(qx);
		quat_ch.quat_y <= comp_t'(qy);
		quat_ch.quat_z <= comp_t'(qz);
		do @(posedge clk); while (!quat_ch.ready);
		e = euler_from_quat(comp_t'(qw), comp_t'(qx), comp_t'(qy), comp_t'(qz),
			thr_shadow);
		if (e.rcase == CASE_NORTH || e.rcase == CASE_SOUTH)
			pole_hits++;
		angle_queue.push_back(e);
		sent++;
	endtask

	task automatic wait_drained();
		quat_ch.valid <= 1'b0;
		@(posedge clk);
		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [1:0] addr, logic [31:0] data,
			output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_threshold(logic [1:0] addr, logic [31:0] data);
		logic [31:0] rd;
		wait_drained();
		apb_access(1'b1, addr, data, rd);
		if (addr == ADDR_THR)
			thr_shadow = data[THR_W-1:0];
		apb_access(1'b0, ADDR_THR, '0, rd);
		if (rd[THR_W-1:0] !== thr_shadow) begin
			$error("pole_threshold: expected %0d actual %0d", thr_shadow, rd[THR_W-1:0]);
			errs++;
		end
	endtask

	task automatic send_mixed();
		comp_t c[4];
		int k, m, b;
		k = $urandom_range(9);
		if (k <= 3) begin
			foreach (c[i]) c[i] = comp_t'($urandom);
		end else if (k <= 6) begin
			m = $urandom_range(1, 14);
			foreach (c[i]) c[i] = comp_t'($urandom_range(0, 2 << m) - (1 << m));
		end else if (k <= 8) begin
			// near a pole when w is not negated: |x|~|y|~|z|~|w|, sign of xy+zw chosen
			b = $urandom_range(2000, 14000);
			foreach (c[i]) c[i] = comp_t'(b + $urandom_range(0, 200) - 100);
			if ($urandom_range(1)) c[0] = -c[0];
			if ($urandom_range(1)) begin
				c[1] = -c[1];
				c[3] = -c[3];
			end
			if ($urandom_range(1)) begin
				c[2] = -c[2];
				c[3] = -c[3];
			end
		end else begin
			foreach (c[i]) c[i] = '0;
			if ($urandom_range(3) != 0)
				c[$urandom_range(3)] = comp_t'($urandom);
		end
		send_quat(int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]));
	endtask

	task automatic test_directed();
		send_quat(0, 0, 0, 0);
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(0, 16384, 0, 0);
		send_quat(0, -16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(8192, 8192, -8192, -8192);
		send_quat(0, 11585, 11585, 0);
		send_quat(0, 11585, -11585, 0);
		send_quat(11585, 0, 0, 11585);
		send_quat(8190, 8192, 8190, 8192);
		send_quat(1, 0, 0, 0);
		send_quat(0, 0, 0, -1);
		send_quat(-1, -1, 1, 1);
		send_quat(5793, 11585, 0, 0);
	endtask

	task automatic test_threshold_extremes();
		set_threshold(ADDR_THR, 32'd0);
		send_quat(16384, 0, 0, 0);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(100, 3, 4, 100);
		repeat (100) send_mixed();
		set_threshold(ADDR_THR, 32'd8192);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(0, 11585, 11585, 0);
		repeat (150) send_mixed();
		set_threshold(ADDR_THR, 32'hFFFF_FFFF);
		send_quat(0, 11585, 11585, 0);
		repeat (150) send_mixed();
		set_threshold(ADDR_THR + 2'd1, 32'd100);
		repeat (50) send_mixed();
		set_threshold(ADDR_THR, 32'hABCD_0000 | 32'd8000);
		repeat (150) send_mixed();
		set_threshold(ADDR_THR, 32'(THR_RESET));
	endtask

	task automatic test_random();
		repeat (250) send_mixed();
	endtask

	task automatic test_no_idle();
		no_idle = 1'b1;
		repeat (200) send_mixed();
		no_idle = 1'b0;
	endtask

	task automatic test_pause();
		repeat (20) send_mixed();
		wait_drained();
		repeat (20) send_mixed();
	endtask

	always @(posedge clk) begin
		euler_ch.ready <= no_idle || ($urandom_range(99) >= 35);
		if (euler_ch.valid && euler_ch.ready) begin
			if (angle_queue.size() == 0) begin
				$error("unexpected result transfer");
				errs++;
			end else begin
				euler_exp_t e;
				e = angle_queue.pop_front();
				checked++;
				if (euler_ch.roll_angle !== e.roll) begin
					$error("roll_angle: expected %0d actual %0d", e.roll, euler_ch.roll_angle);
					errs++;
				end
				if (euler_ch.pitch_angle !== e.pitch) begin
					$error("pitch_angle: expected %0d actual %0d", e.pitch,
						euler_ch.pitch_angle);
					errs++;
				end
				if (euler_ch.yaw_angle !== e.yaw) begin
					$error("yaw_angle: expected %0d actual %0d", e.yaw, euler_ch.yaw_angle);
					errs++;
				end
				if (euler_ch.result_case !== e.rcase) begin
					$error("result_case: expected %0d actual %0d", e.rcase,
						euler_ch.result_case);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", angle_queue.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_pause();
		test_threshold_extremes();
		test_no_idle();
		wait_drained();
		$display("%0d quaternions sent, %0d results checked, %0d at a pole;", sent, checked,
			pole_hits);
		$display("thresholds 0, 8192, 16383, 8000 and reset value exercised");
		if (errs == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_quat_if.sv
rtl/qte_euler_if.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles_top.sv
sim/testbench.sv
